// ===== rtl/core/assert_macros.svh =====
// assertion macros used by variable_file_parser.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define VFP_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define VFP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/vfp_pkg.sv =====
// types, codes and constants of the variable file parser
package vfp_pkg;

    localparam int SIG_LEN       = 11;
    localparam int COMMENT_LEN   = 42;
    localparam int ENTRY_HDR_LEN = 17;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [15:0] HDR_WORD_A  = 16'h000B;
    localparam logic [15:0] HDR_WORD_B  = 16'h000D;
    localparam int          ARCHIVE_BIT = 7;

    // result kinds
    localparam logic [2:0] KIND_SKIP    = 3'd0;
    localparam logic [2:0] KIND_COMMENT = 3'd1;
    localparam logic [2:0] KIND_NAME    = 3'd2;
    localparam logic [2:0] KIND_DESC    = 3'd3;
    localparam logic [2:0] KIND_DATA    = 3'd4;
    localparam logic [2:0] KIND_DONE    = 3'd5;
    localparam logic [2:0] KIND_ERROR   = 3'd6;

    // error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_BAD_SIG  = 2'd1;
    localparam logic [1:0] ERR_BAD_HDR  = 2'd2;
    localparam logic [1:0] ERR_LEN_DIFF = 2'd3;

    // checksum operations for the back end
    localparam logic [1:0] SUM_HOLD  = 2'd0;
    localparam logic [1:0] SUM_CLEAR = 2'd1;
    localparam logic [1:0] SUM_ADD   = 2'd2;

    // one classified byte, passed from front end to back end
    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data_byte;
        logic [15:0] data_offset;
        logic [7:0]  entry_type;
        logic [15:0] entry_size;
        logic        archived;
        logic [1:0]  error_code;
        logic [1:0]  sum_op;
        logic [7:0]  sum_byte;
        logic [15:0] trail_word;
    } vfp_rec_t;

    // queue status seen by the top level
    typedef struct packed {
        logic                               rec_valid;
        logic                               can_push;
        logic [$clog2(QUEUE_DEPTH+1)-1:0]   level;
    } vfp_qstat_t;

    function automatic logic [7:0] magic_byte(input logic [3:0] idx);
        logic [7:0] val;
        case (idx)
            4'd0:    val = 8'h2A;
            4'd1:    val = 8'h2A;
            4'd2:    val = 8'h54;
            4'd3:    val = 8'h49;
            4'd4:    val = 8'h38;
            4'd5:    val = 8'h33;
            4'd6:    val = 8'h46;
            4'd7:    val = 8'h2A;
            4'd8:    val = 8'h1A;
            4'd9:    val = 8'h0A;
            4'd10:   val = 8'h00;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

// ===== rtl/core/variable_file_parser.sv =====
// variable file parser: one result per accepted byte, passed through the queue and the output register
// throughput one byte per cycle while the queue has a free slot and the result side is not stalled
// front end and back end are decoupled by a two-slot queue, so either side may stall alone
// an accepted byte is written into a queue slot, then popped into the output register behind m_tvalid
// synchronous active-low reset: parser idle, queue empty, checksum zero, no result pending
`include "assert_macros.svh"

module variable_file_parser
    import vfp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // input byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tuser,   // [0] start_of_file
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // [2:0] kind, [10:3] out_byte, [26:11] data_offset, [34:27] entry_type,
    // [50:35] entry_size, [51] archived, [53:52] error_code, [54] checksum_ok,
    // [70:55] computed_sum, [71] zero
    output logic [71:0] m_tdata
);

    logic       in_accept;
    logic       q_pop;
    vfp_rec_t   front_rec;
    vfp_rec_t   head_rec;
    vfp_qstat_t q_stat;

    // a new request is taken whenever the queue has a free slot
    assign s_tready  = q_stat.can_push;
    assign in_accept = s_tvalid && s_tready;

    // phase machine, counters and header fields; classifies each byte
    vfp_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (in_accept),
        .in_byte       (s_tdata),
        .start_of_file (s_tuser),
        .rec           (front_rec)
    );

    // classified bytes wait here while the result side is stalled
    vfp_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (in_accept),
        .push_rec (front_rec),
        .pop      (q_pop),
        .head_rec (head_rec),
        .stat     (q_stat)
    );

    // running body sum, trailer compare and registered result
    vfp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rec_valid (q_stat.rec_valid),
        .rec       (head_rec),
        .pop       (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // error results always carry a code, other results never do
    `VFP_ASSERT_NOW(a_err_code, aclk, aresetn, m_tvalid && (m_tdata[2:0] == KIND_ERROR), m_tdata[53:52] != ERR_NONE, "error result without error code")
    `VFP_ASSERT_NOW(a_no_code, aclk, aresetn, m_tvalid && (m_tdata[2:0] != KIND_ERROR), m_tdata[53:52] == ERR_NONE, "error code on a non-error result")
    // only data bytes carry an offset
    `VFP_ASSERT_NOW(a_offset, aclk, aresetn, m_tvalid && (m_tdata[2:0] != KIND_DATA), m_tdata[26:11] == 16'd0, "data offset on a non-data result")
    // the queue never holds more than its depth
    `VFP_ASSERT_NOW(a_level, aclk, aresetn, 1'b1, q_stat.level <= 2'(QUEUE_DEPTH), "queue level above depth")

endmodule

// ===== rtl/core/vfp_front.sv =====
// front end: file phase tracking, header capture and byte classification
module vfp_front
    import vfp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        accept,
    input  logic [7:0]  in_byte,
    input  logic        start_of_file,
    output vfp_rec_t    rec
);

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_SIG     = 3'd1;
    localparam logic [2:0] PH_COMMENT = 3'd2;
    localparam logic [2:0] PH_BLEN    = 3'd3;
    localparam logic [2:0] PH_EHDR    = 3'd4;
    localparam logic [2:0] PH_EDATA   = 3'd5;
    localparam logic [2:0] PH_TRAIL   = 3'd6;
    localparam logic [2:0] PH_HALT    = 3'd7;

    logic [2:0]  phase_reg, phase_next;
    logic [15:0] field_count_reg, field_count_next;
    logic [17:0] body_count_reg, body_count_next;
    logic        sig_bad_reg, sig_bad_next;
    logic [15:0] body_length_reg, body_length_next;
    logic [15:0] header_word_reg, header_word_next;
    logic [15:0] first_length_reg, first_length_next;
    logic [15:0] second_length_reg, second_length_next;
    logic [7:0]  type_byte_reg, type_byte_next;
    logic [7:0]  flags_byte_reg, flags_byte_next;
    logic [7:0]  trailer_low_reg, trailer_low_next;

    logic [2:0]  ph;
    logic [15:0] fc, fc_inc;
    logic [17:0] bc, bc_inc;
    logic        sb, sig_bad_now, body_done;
    logic [15:0] blen_full, len_copy;

    always_comb begin
        rec                = '0;
        rec.kind           = KIND_SKIP;
        rec.error_code     = ERR_NONE;
        rec.sum_op         = SUM_HOLD;
        rec.sum_byte       = in_byte;
        body_length_next   = body_length_reg;
        header_word_next   = header_word_reg;
        first_length_next  = first_length_reg;
        second_length_next = second_length_reg;
        type_byte_next     = type_byte_reg;
        flags_byte_next    = flags_byte_reg;
        trailer_low_next   = trailer_low_reg;

        ph = phase_reg;
        fc = field_count_reg;
        sb = sig_bad_reg;
        bc = body_count_reg;
        if (start_of_file) begin
            ph         = PH_SIG;
            fc         = '0;
            sb         = 1'b0;
            bc         = '0;
            rec.sum_op = SUM_CLEAR;
        end

        phase_next       = ph;
        field_count_next = fc;
        sig_bad_next     = sb;
        body_count_next  = bc;
        fc_inc           = fc + 16'd1;
        bc_inc           = bc + 18'd1;
        body_done        = (bc_inc >= {2'b00, body_length_reg});
        sig_bad_now      = sb | (in_byte != magic_byte(fc[3:0]));
        blen_full        = {in_byte, body_length_reg[7:0]};
        len_copy         = {in_byte, second_length_reg[7:0]};

        case (ph)
            PH_SIG: begin
                sig_bad_next     = sig_bad_now;
                field_count_next = fc_inc;
                if (fc_inc >= 16'(SIG_LEN)) begin
                    field_count_next = '0;
                    if (sig_bad_now) begin
                        rec.kind       = KIND_ERROR;
                        rec.error_code = ERR_BAD_SIG;
                        phase_next     = PH_HALT;
                    end else begin
                        phase_next = PH_COMMENT;
                    end
                end
            end
            PH_COMMENT: begin
                rec.kind         = KIND_COMMENT;
                rec.data_byte    = in_byte;
                field_count_next = fc_inc;
                if (fc_inc >= 16'(COMMENT_LEN)) begin
                    field_count_next = '0;
                    phase_next       = PH_BLEN;
                end
            end
            PH_BLEN: begin
                if (fc == 16'd0) begin
                    body_length_next = {8'h00, in_byte};
                    field_count_next = 16'd1;
                end else begin
                    body_length_next = blen_full;
                    rec.sum_op       = SUM_CLEAR;
                    body_count_next  = '0;
                    field_count_next = '0;
                    phase_next       = (blen_full == 16'd0) ? PH_TRAIL : PH_EHDR;
                end
            end
            PH_EHDR: begin
                rec.sum_op      = SUM_ADD;
                body_count_next = bc_inc;
                case (fc[4:0])
                    5'd0:  header_word_next   = {8'h00, in_byte};
                    5'd1:  header_word_next   = {in_byte, header_word_reg[7:0]};
                    5'd2:  first_length_next  = {8'h00, in_byte};
                    5'd3:  first_length_next  = {in_byte, first_length_reg[7:0]};
                    5'd4:  type_byte_next     = in_byte;
                    5'd14: flags_byte_next    = in_byte;
                    5'd15: second_length_next = {8'h00, in_byte};
                    5'd16: second_length_next = len_copy;
                    default: begin
                        if (fc >= 16'd5 && fc <= 16'd12) begin
                            rec.kind      = KIND_NAME;
                            rec.data_byte = in_byte;
                        end
                    end
                endcase
                field_count_next = fc_inc;
                if (fc_inc >= 16'(ENTRY_HDR_LEN)) begin
                    field_count_next = '0;
                    if (header_word_reg != HDR_WORD_A && header_word_reg != HDR_WORD_B) begin
                        rec.kind       = KIND_ERROR;
                        rec.error_code = ERR_BAD_HDR;
                        phase_next     = PH_HALT;
                    end else if (first_length_reg != len_copy) begin
                        rec.kind       = KIND_ERROR;
                        rec.error_code = ERR_LEN_DIFF;
                        phase_next     = PH_HALT;
                    end else begin
                        rec.kind       = KIND_DESC;
                        rec.entry_type = type_byte_reg;
                        rec.entry_size = first_length_reg;
                        rec.archived   = flags_byte_reg[ARCHIVE_BIT];
                        if (first_length_reg == 16'd0) begin
                            phase_next = body_done ? PH_TRAIL : PH_EHDR;
                        end else begin
                            phase_next = PH_EDATA;
                        end
                    end
                end
            end
            PH_EDATA: begin
                rec.sum_op       = SUM_ADD;
                body_count_next  = bc_inc;
                rec.kind         = KIND_DATA;
                rec.data_byte    = in_byte;
                rec.data_offset  = fc;
                field_count_next = fc_inc;
                if (fc_inc >= first_length_reg) begin
                    field_count_next = '0;
                    phase_next       = body_done ? PH_TRAIL : PH_EHDR;
                end
            end
            PH_TRAIL: begin
                if (fc == 16'd0) begin
                    trailer_low_next = in_byte;
                    field_count_next = 16'd1;
                end else begin
                    rec.kind         = KIND_DONE;
                    rec.trail_word   = {in_byte, trailer_low_reg};
                    field_count_next = '0;
                    phase_next       = PH_HALT;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            field_count_reg <= '0;
            body_count_reg  <= '0;
            sig_bad_reg     <= 1'b0;
        end else if (accept) begin
            phase_reg       <= phase_next;
            field_count_reg <= field_count_next;
            body_count_reg  <= body_count_next;
            sig_bad_reg     <= sig_bad_next;
        end
    end

    // header fields are always written before they are used
    always_ff @(posedge aclk) begin
        if (accept) begin
            body_length_reg   <= body_length_next;
            header_word_reg   <= header_word_next;
            first_length_reg  <= first_length_next;
            second_length_reg <= second_length_next;
            type_byte_reg     <= type_byte_next;
            flags_byte_reg    <= flags_byte_next;
            trailer_low_reg   <= trailer_low_next;
        end
    end

endmodule

// ===== rtl/core/vfp_queue.sv =====
// two-slot queue between front end and back end
module vfp_queue
    import vfp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  vfp_rec_t    push_rec,
    input  logic        pop,
    output vfp_rec_t    head_rec,
    output vfp_qstat_t  stat
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

    vfp_rec_t    slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [LVL_W-1:0] level_reg, level_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        level_next  = level_reg + LVL_W'(push) - LVL_W'(pop);
    end

    assign head_rec       = slot_reg[rd_ptr_reg];
    assign stat.rec_valid = (level_reg != '0);
    assign stat.can_push  = (level_reg != LVL_W'(QUEUE_DEPTH));
    assign stat.level     = level_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

// ===== rtl/core/vfp_back.sv =====
// back end: body checksum, trailer compare and output register
module vfp_back
    import vfp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        rec_valid,
    input  vfp_rec_t    rec,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata
);

    logic        m_tvalid_reg, m_tvalid_next;
    logic [71:0] m_tdata_reg, m_tdata_next;
    logic [15:0] running_sum_reg, running_sum_next;
    logic        checksum_ok;

    assign pop = rec_valid && (!m_tvalid_reg || m_tready);

    always_comb begin
        running_sum_next = running_sum_reg;
        m_tvalid_next    = m_tvalid_reg;
        m_tdata_next     = m_tdata_reg;
        checksum_ok      = (rec.kind == KIND_DONE) && (running_sum_reg == rec.trail_word);
        if (pop) begin
            case (rec.sum_op)
                SUM_CLEAR: running_sum_next = '0;
                SUM_ADD:   running_sum_next = running_sum_reg + {8'h00, rec.sum_byte};
                default:   running_sum_next = running_sum_reg;
            endcase
            m_tvalid_next = 1'b1;
            m_tdata_next  = {1'b0, running_sum_next, checksum_ok, rec.error_code,
                             rec.archived, rec.entry_size, rec.entry_type,
                             rec.data_offset, rec.data_byte, rec.kind};
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg    <= 1'b0;
            running_sum_reg <= '0;
        end else begin
            m_tvalid_reg    <= m_tvalid_next;
            running_sum_reg <= running_sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== tb/variable_file_parser_test.sv =====
// self-checking testbench for the variable file parser: file streams against a local parse model
`timescale 1ns / 100ps

module variable_file_parser_test
    import vfp_pkg::*;
();

    // signature bytes, byte 0 in the low bits
    localparam logic [87:0] SIG_BYTES = {8'h00, 8'h0A, 8'h1A, 8'h2A, 8'h46, 8'h33,
                                         8'h38, 8'h49, 8'h54, 8'h2A, 8'h2A};
    localparam int RANDOM_BYTES = 150;
    localparam int STALL_PCT    = 25;
    localparam int PRINT_CAP    = 50;

    typedef enum logic [2:0] {
        PH_IDLE, PH_SIG, PH_COMMENT, PH_BLEN, PH_EHDR, PH_EDATA, PH_TRAIL, PH_HALT
    } parse_phase_t;

    // one result as packed on m_tdata[70:0], last member in the low bits
    typedef struct packed {
        logic [15:0] computed_sum;
        logic        checksum_ok;
        logic [1:0]  error_code;
        logic        archived;
        logic [15:0] entry_size;
        logic [7:0]  entry_type;
        logic [15:0] data_offset;
        logic [7:0]  out_byte;
        logic [2:0]  kind;
    } parse_result_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] in_byte
    logic        s_tuser  = 1'b0;    // [0] start_of_file
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // [2:0] kind, [10:3] out_byte, [26:11] data_offset, [34:27] entry_type,
    // [50:35] entry_size, [51] archived, [53:52] error_code, [54] checksum_ok,
    // [70:55] computed_sum, [71] zero
    logic [71:0] m_tdata;

    variable_file_parser dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // parse model state
    parse_phase_t phase_q;
    logic [15:0]  field_cnt;
    logic [17:0]  body_cnt;
    logic [15:0]  body_len;
    logic [15:0]  run_sum;
    logic         sig_bad;
    logic [15:0]  hdr_word;
    logic [15:0]  len_a;
    logic [15:0]  len_b;
    logic [7:0]   type_q;
    logic [7:0]   flags_q;
    logic [7:0]   trail_lo;

    parse_result_t expected_results[$];
    logic [7:0]    body_q[$];        // body of the file being built
    bit            stall_en = 1'b1;
    int            mismatch_count = 0;
    int            result_count = 0;
    int            parsed_bytes = 0; // requests that were not simply ignored

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // ---------------------------------------------------------------- parse model

    function automatic void clear_parser();
        phase_q   = PH_IDLE;
        field_cnt = '0;
        body_cnt  = '0;
        body_len  = '0;
        run_sum   = '0;
        sig_bad   = 1'b0;
        hdr_word  = '0;
        len_a     = '0;
        len_b     = '0;
        type_q    = '0;
        flags_q   = '0;
        trail_lo  = '0;
    endfunction

    // entry boundary: the body ends only here, once the stated length is reached
    function automatic void close_entry();
        field_cnt = '0;
        phase_q   = (body_cnt >= {2'b00, body_len}) ? PH_TRAIL : PH_EHDR;
    endfunction

    function automatic void add_to_body(input logic [7:0] b);
        run_sum  = run_sum + {8'h00, b};
        body_cnt = body_cnt + 18'd1;
    endfunction

    function automatic parse_result_t parse_byte(input logic [7:0] b, input logic sof);
        parse_result_t r;
        r = '0;
        // start of file restarts parsing, even mid-file
        if (sof) begin
            clear_parser();
            phase_q = PH_SIG;
        end
        case (phase_q)
            PH_SIG: begin
                if (field_cnt >= SIG_LEN || b != SIG_BYTES[field_cnt[3:0]*8 +: 8])
                    sig_bad = 1'b1;
                field_cnt++;
                // a bad signature is reported once, on its last byte
                if (field_cnt >= SIG_LEN) begin
                    field_cnt = '0;
                    if (sig_bad) begin
                        r.kind       = KIND_ERROR;
                        r.error_code = ERR_BAD_SIG;
                        phase_q      = PH_HALT;
                    end else begin
                        phase_q = PH_COMMENT;
                    end
                end
            end
            PH_COMMENT: begin
                r.kind     = KIND_COMMENT;
                r.out_byte = b;
                field_cnt++;
                if (field_cnt >= COMMENT_LEN) begin
                    field_cnt = '0;
                    phase_q   = PH_BLEN;
                end
            end
            PH_BLEN: begin
                if (field_cnt == 0) begin
                    body_len  = {8'h00, b};
                    field_cnt = 16'd1;
                end else begin
                    body_len[15:8] = b;
                    run_sum        = '0;
                    body_cnt       = '0;
                    close_entry();  // zero body length goes straight to the trailer
                end
            end
            PH_EHDR: begin
                add_to_body(b);
                case (field_cnt)
                    16'd0:   hdr_word = {8'h00, b};
                    16'd1:   hdr_word[15:8] = b;
                    16'd2:   len_a = {8'h00, b};
                    16'd3:   len_a[15:8] = b;
                    16'd4:   type_q = b;
                    16'd14:  flags_q = b;
                    16'd15:  len_b = {8'h00, b};
                    16'd16:  len_b[15:8] = b;
                    default: begin
                        if (field_cnt >= 5 && field_cnt <= 12) begin
                            r.kind     = KIND_NAME;
                            r.out_byte = b;
                        end
                    end
                endcase
                field_cnt++;
                // checks on the last header byte: header word first, then lengths
                if (field_cnt >= ENTRY_HDR_LEN) begin
                    field_cnt = '0;
                    if (hdr_word != HDR_WORD_A && hdr_word != HDR_WORD_B) begin
                        r.kind       = KIND_ERROR;
                        r.error_code = ERR_BAD_HDR;
                        phase_q      = PH_HALT;
                    end else if (len_a != len_b) begin
                        r.kind       = KIND_ERROR;
                        r.error_code = ERR_LEN_DIFF;
                        phase_q      = PH_HALT;
                    end else begin
                        r.kind       = KIND_DESC;
                        r.entry_type = type_q;
                        r.entry_size = len_a;
                        r.archived   = flags_q[ARCHIVE_BIT];
                        if (len_a == 0)
                            close_entry();
                        else
                            phase_q = PH_EDATA;
                    end
                end
            end
            PH_EDATA: begin
                add_to_body(b);
                r.kind        = KIND_DATA;
                r.out_byte    = b;
                r.data_offset = field_cnt;
                field_cnt++;
                if (field_cnt >= len_a)
                    close_entry();
            end
            PH_TRAIL: begin
                if (field_cnt == 0) begin
                    trail_lo  = b;
                    field_cnt = 16'd1;
                end else begin
                    // checksum mismatch is not fatal, only flagged
                    r.kind        = KIND_DONE;
                    r.checksum_ok = (run_sum == {b, trail_lo});
                    field_cnt     = '0;
                    phase_q       = PH_HALT;
                end
            end
            default: ;
        endcase
        r.computed_sum = run_sum;
        return r;
    endfunction

    // ---------------------------------------------------------------- request side

    task automatic send_byte(input logic [7:0] b, input logic sof);
        parse_result_t want;
        bit            counted;
        // random gap before the request
        if (stall_en && $urandom_range(0, 99) < STALL_PCT) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= sof;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        counted = sof || (phase_q != PH_IDLE && phase_q != PH_HALT);
        want = parse_byte(b, sof);
        expected_results.push_back(want);
        if (counted)
            parsed_bytes++;
    endtask

    // entry header plus data_n random data bytes, appended to the body under construction
    function automatic void add_entry(input logic [15:0] word, input logic [15:0] len1,
                                      input logic [15:0] len2, input logic [7:0] etype,
                                      input logic [7:0] flags, input int data_n);
        body_q.push_back(word[7:0]);
        body_q.push_back(word[15:8]);
        body_q.push_back(len1[7:0]);
        body_q.push_back(len1[15:8]);
        body_q.push_back(etype);
        repeat (8) body_q.push_back(8'($urandom));  // name
        body_q.push_back(8'($urandom));             // version
        body_q.push_back(flags);
        body_q.push_back(len2[7:0]);
        body_q.push_back(len2[15:8]);
        repeat (data_n) body_q.push_back(8'($urandom));
    endfunction

    function automatic logic [15:0] body_sum();
        logic [15:0] s;
        s = '0;
        foreach (body_q[i])
            s = s + {8'h00, body_q[i]};
        return s;
    endfunction

    // sends signature, comment, body length, body and trailer; cut > 0 stops early
    task automatic send_file(input bit sig_ok, input logic [15:0] blen,
                             input logic [15:0] trailer, input int cut);
        logic [7:0] file_q[$];
        int         n;
        int         bad_idx;
        for (int i = 0; i < SIG_LEN; i++)
            file_q.push_back(SIG_BYTES[i*8 +: 8]);
        if (!sig_ok) begin
            bad_idx = $urandom_range(0, SIG_LEN - 1);
            file_q[bad_idx] = file_q[bad_idx] ^ (8'h01 << $urandom_range(0, 7));
        end
        repeat (COMMENT_LEN) file_q.push_back(8'($urandom));
        file_q.push_back(blen[7:0]);
        file_q.push_back(blen[15:8]);
        foreach (body_q[i])
            file_q.push_back(body_q[i]);
        file_q.push_back(trailer[7:0]);
        file_q.push_back(trailer[15:8]);
        n = (cut > 0 && cut < file_q.size()) ? cut : file_q.size();
        for (int i = 0; i < n; i++)
            send_byte(file_q[i], i == 0);
        body_q.delete();
    endtask

    // ---------------------------------------------------------------- result side

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        // keep the log short when something is badly broken
        if (mismatch_count <= PRINT_CAP)
            $display("%0t ns result %0d: %s", $realtime, result_count, msg);
    endtask

    task automatic check_result(input logic [71:0] word);
        parse_result_t got;
        parse_result_t want;
        got = word[70:0];
        if (expected_results.size() == 0) begin
            flag_mismatch($sformatf("result %h with no request pending", word));
        end else begin
            want = expected_results.pop_front();
            if (word[71])
                flag_mismatch("pad bit set");
            if (got.kind != want.kind)
                flag_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
            if (got.out_byte != want.out_byte)
                flag_mismatch($sformatf("out_byte %h, want %h", got.out_byte, want.out_byte));
            if (got.data_offset != want.data_offset)
                flag_mismatch($sformatf("data_offset %0d, want %0d",
                                        got.data_offset, want.data_offset));
            if (got.entry_type != want.entry_type)
                flag_mismatch($sformatf("entry_type %h, want %h",
                                        got.entry_type, want.entry_type));
            if (got.entry_size != want.entry_size)
                flag_mismatch($sformatf("entry_size %0d, want %0d",
                                        got.entry_size, want.entry_size));
            if (got.archived != want.archived)
                flag_mismatch($sformatf("archived %b, want %b", got.archived, want.archived));
            if (got.error_code != want.error_code)
                flag_mismatch($sformatf("error_code %0d, want %0d",
                                        got.error_code, want.error_code));
            if (got.checksum_ok != want.checksum_ok)
                flag_mismatch($sformatf("checksum_ok %b, want %b",
                                        got.checksum_ok, want.checksum_ok));
            if (got.computed_sum != want.computed_sum)
                flag_mismatch($sformatf("computed_sum %h, want %h",
                                        got.computed_sum, want.computed_sum));
        end
        result_count++;
    endtask

    // results are checked at the edge that accepts them; ready stalls at random while stalls are enabled
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            check_result(m_tdata);
        m_tready <= stall_en ? ($urandom_range(0, 99) >= STALL_PCT) : 1'b1;
    end

    // ---------------------------------------------------------------- tests

    // bytes before any start of file are skipped
    task automatic test_idle_noise();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h2A, 1'b0);
    endtask

    // both header words, archived and plain flags, empty entries mid-body and last
    task automatic test_clean_file();
        add_entry(HDR_WORD_A, 16'd3, 16'd3, 8'hFF, 8'h80, 3);
        add_entry(HDR_WORD_B, 16'd0, 16'd0, 8'h00, 8'h7F, 0);
        add_entry(HDR_WORD_B, 16'd1, 16'd1, 8'h15, 8'hFF, 1);
        add_entry(HDR_WORD_A, 16'd0, 16'd0, 8'h06, 8'h00, 0);
        send_file(1'b1, 16'(body_q.size()), body_sum(), 0);
        // ignored after done
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
    endtask

    // zero body length goes straight to the trailer, good and bad sum
    task automatic test_empty_body();
        send_file(1'b1, 16'h0000, 16'h0000, 0);
        send_file(1'b1, 16'h0000, 16'hFFFF, 0);
    endtask

    task automatic test_bad_signature();
        add_entry(HDR_WORD_A, 16'd2, 16'd2, 8'h01, 8'h00, 2);
        send_file(1'b0, 16'(body_q.size()), body_sum(), 0);
    endtask

    // header word checked as a full 16-bit value
    task automatic test_bad_entry_header();
        add_entry(16'h010B, 16'd1, 16'd1, 8'h01, 8'h00, 1);
        send_file(1'b1, 16'(body_q.size()), body_sum(), 0);
        add_entry(HDR_WORD_B, 16'd0, 16'd0, 8'h02, 8'h80, 0);
        add_entry(16'h000C, 16'd1, 16'd1, 8'h01, 8'h00, 1);
        send_file(1'b1, 16'(body_q.size()), body_sum(), 0);
    endtask

    task automatic test_length_mismatch();
        add_entry(HDR_WORD_A, 16'hFFFF, 16'h0000, 8'h04, 8'h80, 0);
        send_file(1'b1, 16'(body_q.size()), body_sum(), 0);
        add_entry(HDR_WORD_B, 16'h0000, 16'h8000, 8'h04, 8'h00, 0);
        send_file(1'b1, 16'(body_q.size()), body_sum(), 0);
    endtask

    task automatic test_checksum_mismatch();
        add_entry(HDR_WORD_B, 16'd4, 16'd4, 8'h05, 8'h80, 4);
        send_file(1'b1, 16'(body_q.size()), ~body_sum(), 0);
    endtask

    // entry running past the stated body length is parsed whole
    task automatic test_overrun();
        add_entry(HDR_WORD_A, 16'd5, 16'd5, 8'h0C, 8'h00, 5);
        send_file(1'b1, 16'd1, body_sum(), 0);
    endtask

    // start of file in the signature, the comment and entry data
    task automatic test_restart();
        send_file(1'b1, 16'd0, 16'd0, 5);
        send_file(1'b1, 16'd0, 16'd0, 30);
        add_entry(HDR_WORD_A, 16'd6, 16'd6, 8'h03, 8'h80, 6);
        send_file(1'b1, 16'(body_q.size()), body_sum(), 11 + 42 + 2 + 17 + 3);
        add_entry(HDR_WORD_B, 16'd2, 16'd2, 8'h03, 8'h00, 2);
        send_file(1'b1, 16'(body_q.size()), body_sum(), 0);
    endtask

    // long entry sent with no idling on either side
    task automatic test_long_entry();
        stall_en = 1'b0;
        add_entry(HDR_WORD_A, 16'd48, 16'd48, 8'hA5, 8'h80, 48);
        send_file(1'b1, 16'(body_q.size()), body_sum(), 0);
        stall_en = 1'b1;
    endtask

    // one random file: mostly well formed, the rest broken in one main way; the trailer may also be wrong
    task automatic random_file();
        int          flavor;
        int          n_ent;
        int          len;
        int          cut;
        logic [15:0] word;
        logic [15:0] len2;
        logic [15:0] blen;
        logic [15:0] trailer;
        flavor = $urandom_range(0, 99);
        n_ent  = $urandom_range(0, 3);
        if (n_ent == 0 && flavor >= 67 && flavor < 82)
            n_ent = 1;
        for (int i = 0; i < n_ent; i++) begin
            len  = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
            word = $urandom_range(0, 1) ? HDR_WORD_A : HDR_WORD_B;
            len2 = 16'(len);
            if (i == n_ent - 1 && flavor >= 67 && flavor < 75) begin
                word = 16'($urandom);
                if (word == HDR_WORD_A || word == HDR_WORD_B)
                    word = word ^ 16'h0100;
            end
            if (i == n_ent - 1 && flavor >= 75 && flavor < 82)
                len2 = len2 ^ 16'($urandom_range(1, 65535));
            add_entry(word, 16'(len), len2, 8'($urandom), 8'($urandom), len);
        end
        blen = 16'(body_q.size());
        if (flavor >= 82 && flavor < 90)
            blen = 16'($urandom_range(0, 60));
        trailer = body_sum();
        if ($urandom_range(0, 9) == 0)
            trailer = 16'($urandom);
        cut = (flavor >= 90) ? $urandom_range(1, 56 + body_q.size()) : 0;
        send_file(!(flavor >= 60 && flavor < 67), blen, trailer, cut);
        // stray bytes between files, now and then one that restarts
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom), $urandom_range(0, 15) == 0);
    endtask

    task automatic test_random_files();
        int first;
        first = parsed_bytes;
        while (parsed_bytes - first < RANDOM_BYTES)
            random_file();
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        int waited;
        clear_parser();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        test_idle_noise();
        test_clean_file();
        test_empty_body();
        test_bad_signature();
        test_bad_entry_header();
        test_length_mismatch();
        test_checksum_mismatch();
        test_overrun();
        test_restart();
        test_long_entry();
        test_random_files();
        s_tvalid <= 1'b0;

        // drain, then keep watching for anything unexpected to show up
        waited = 0;
        while (expected_results.size() != 0 && waited < 2000) begin
            @(posedge aclk);
            waited++;
        end
        if (expected_results.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", expected_results.size()));
        repeat (8) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("variable_file_parser verification clean");
        end else begin
            $display("variable_file_parser verification failed");
        end
        $finish;
    end

    // hang guard, far beyond the slowest correct run
    initial begin
        #10_000_000;
        $display("variable_file_parser verification failed");
        $finish;
    end

endmodule
